>>> hw/rtl/lru_page_replacement_macros.svh
// Assertion macros shared by the checker files of the page replacement unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRUPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru page replacement check failed");

// Consequent must hold in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru page replacement check failed");

`endif

>>> hw/rtl/lrupr_pkg.sv
// Shared constants, types and controller states of the LRU page replacement unit.
// No dependencies; every other file of the block but the macro header imports this package.
package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int MISS_W    = 32;
  localparam int CFG_RESET = 8;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_idx_t;
  typedef logic [MISS_W-1:0]    miss_cnt_t;

  // Running search result handed from one cell to the next.
  typedef struct packed {
    logic       hit_found;
    frame_idx_t hit_idx;
    frame_idx_t hit_rank;
    logic       empty_found;
    frame_idx_t empty_idx;
    logic       lru_found;
    frame_idx_t lru_idx;
    frame_idx_t lru_rank;
    page_t      lru_page;
  } scan_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic       apply;
    frame_idx_t slot;
    frame_idx_t limit;
    logic       age_all;
    logic       write_page;
    logic       set_valid;
    page_t      page;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

>>> hw/rtl/lrupr_req_if.sv
// Request channel of the LRU page replacement unit: one page reference.
// Depends on lrupr_pkg for the page type.
interface lrupr_req_if import lrupr_pkg::*; ();

  logic  valid;
  logic  ready;
  page_t page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);

endinterface

>>> hw/rtl/lrupr_rsp_if.sv
// Response channel of the LRU page replacement unit: one lookup result.
// Depends on lrupr_pkg for the field types.
interface lrupr_rsp_if import lrupr_pkg::*; ();

  logic       valid;
  logic       ready;
  logic       hit;
  frame_idx_t frame_index;
  logic       evicted_valid;
  page_t      evicted_page;
  miss_cnt_t  miss_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output miss_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input miss_total, output ready);

endinterface

>>> hw/rtl/lrupr_cell.sv
// One page frame of the LRU chain: page, valid bit and recency rank.
// Depends on lrupr_pkg for the scan and update structs.
module lrupr_cell import lrupr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_idx_t idx,
  input  logic       active,
  input  page_t      key,
  input  scan_t      scan_in,
  output scan_t      scan_out,
  input  cmd_t       cmd
);

  logic       valid;
  frame_idx_t rank;
  page_t      page;
  logic       selected;

  assign selected = (cmd.slot == idx);

  // Fold this frame into the running search: first hit, first empty, oldest.
  always_comb begin
    scan_out = scan_in;
    if (active && valid && (page == key) && !scan_in.hit_found) begin
      scan_out.hit_found = 1'b1;
      scan_out.hit_idx   = idx;
      scan_out.hit_rank  = rank;
    end
    if (active && !valid && !scan_in.empty_found) begin
      scan_out.empty_found = 1'b1;
      scan_out.empty_idx   = idx;
    end
    if (active && valid && (!scan_in.lru_found || (rank > scan_in.lru_rank))) begin
      scan_out.lru_found = 1'b1;
      scan_out.lru_idx   = idx;
      scan_out.lru_rank  = rank;
      scan_out.lru_page  = page;
    end
  end

  // The chosen frame becomes most recent; younger valid frames, or all on a fill, age by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.apply) begin
      if (selected) begin
        rank <= '0;
        if (cmd.set_valid) begin
          valid <= 1'b1;
        end
      end else if (valid && (cmd.age_all || (rank < cmd.limit))) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // Page storage needs no reset; valid bits mark what it holds.
  always_ff @(posedge clk) begin
    if (cmd.apply && selected && cmd.write_page) begin
      page <= cmd.page;
    end
  end

endmodule

>>> hw/rtl/lru_page_replacement.sv
// LRU page replacement unit.
// Requests on req carry one page number each; every request yields exactly one
// response on rsp with hit, frame_index, evicted_valid, evicted_page and the
// saturating miss_total. Both channels use valid/ready, taken on a clock edge
// where both are high. cfg_wr_en with cfg_wr_data sets frames_in_use (0 acts
// as 1, values above the frame count act as the frame count); write it only
// while no request is in flight.
// A request passes through a lookup state, in which the row of frame cells forms
// the hit, empty and oldest-frame search as a ripple from cell to cell, and an
// update state, in which the decision is broadcast back to the cells and the
// response register is loaded. The next request can be taken in the update
// state of the previous one, as that request's update completes.
// A request can be taken while the previous response still waits; the update
// cycle holds while the response register is full and not being drained.
// Reset (rst, synchronous) empties all frames, clears the miss count, sets
// frames_in_use to 8 and drops rsp.valid.
module lru_page_replacement import lrupr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lrupr_req_if.sink          req,
  lrupr_rsp_if.source        rsp,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data
);

  state_t           state;
  state_t           state_next;
  logic [CFG_W-1:0] frames_in_use;
  logic [CNT_W-1:0] active_cnt;
  logic [FRAMES-1:0] active_mask;
  page_t            key;
  cmd_t             cmd;
  cmd_t             cmd_next;
  cmd_t             cmd_cells;
  logic             res_hit;
  logic             res_hit_next;
  logic             res_ev;
  logic             res_ev_next;
  page_t            res_ev_page;
  page_t            res_ev_page_next;
  miss_cnt_t        miss;
  miss_cnt_t        miss_next;
  scan_t            chain [FRAMES+1];
  logic             out_free;
  logic             upd_fire;
  logic             req_fire;

  logic             out_valid;
  logic             out_hit;
  frame_idx_t       out_frame;
  logic             out_ev;
  page_t            out_ev_page;
  miss_cnt_t        out_miss;

  assign req_fire = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Clamp the configured frame count into 1..FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      active_cnt = CNT_W'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      active_cnt = CNT_W'(FRAMES);
    end else begin
      active_cnt = CNT_W'(frames_in_use);
    end
  end

  // Hold the referenced page for the lookup.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      key <= req.page_number;
    end
  end

  // Row of frame cells; the search ripples from frame 0 upward.
  assign chain[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active_mask[i] = (CNT_W'(i) < active_cnt);

    lrupr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (FRAME_W'(i)),
      .active   (active_mask[i]),
      .key      (key),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .cmd      (cmd_cells)
    );
  end

  // Turn the search result into an update command and response fields.
  always_comb begin
    cmd_next            = '0;
    cmd_next.page       = key;
    res_hit_next        = 1'b0;
    res_ev_next         = 1'b0;
    res_ev_page_next    = '0;
    if (chain[FRAMES].hit_found) begin
      res_hit_next   = 1'b1;
      cmd_next.slot  = chain[FRAMES].hit_idx;
      cmd_next.limit = chain[FRAMES].hit_rank;
    end else if (chain[FRAMES].empty_found) begin
      cmd_next.slot       = chain[FRAMES].empty_idx;
      cmd_next.age_all    = 1'b1;
      cmd_next.write_page = 1'b1;
      cmd_next.set_valid  = 1'b1;
    end else begin
      cmd_next.slot       = chain[FRAMES].lru_idx;
      cmd_next.limit      = chain[FRAMES].lru_rank;
      cmd_next.write_page = 1'b1;
      res_ev_next         = 1'b1;
      res_ev_page_next    = chain[FRAMES].lru_page;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      cmd         <= cmd_next;
      res_hit     <= res_hit_next;
      res_ev      <= res_ev_next;
      res_ev_page <= res_ev_page_next;
    end
  end

  // The cells only act in the cycle the update completes.
  always_comb begin
    cmd_cells       = cmd;
    cmd_cells.apply = upd_fire;
  end

  // Saturating miss counter.
  always_comb begin
    if (res_hit || (miss == '1)) begin
      miss_next = miss;
    end else begin
      miss_next = miss + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss <= '0;
    end else if (upd_fire) begin
      miss <= miss_next;
    end
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, request ready and update strobe.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    upd_fire   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          upd_fire   = 1'b1;
          req.ready  = 1'b1;
          state_next = req.valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit     <= res_hit;
      out_frame   <= cmd.slot;
      out_ev      <= res_ev;
      out_ev_page <= res_ev_page;
      out_miss    <= miss_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.frame_index   = out_frame;
  assign rsp.evicted_valid = out_ev;
  assign rsp.evicted_page  = out_ev_page;
  assign rsp.miss_total    = out_miss;

endmodule

>>> hw/rtl/lrupr_checker.sv
// Port-level checks of the LRU page replacement unit, bound to its top level.
// Depends on lrupr_pkg and lru_page_replacement_macros.svh.
`include "lru_page_replacement_macros.svh"

module lrupr_checker import lrupr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_hit,
  input frame_idx_t rsp_frame_index,
  input logic       rsp_evicted_valid,
  input page_t      rsp_evicted_page,
  input miss_cnt_t  rsp_miss_total
);

  logic [FRAME_W+PAGE_BITS+MISS_W+1:0] rsp_fields;

  // All response fields side by side, for the hold check.
  assign rsp_fields = {rsp_hit, rsp_frame_index, rsp_evicted_valid, rsp_evicted_page,
                       rsp_miss_total};

  // A stalled response keeps its contents.
  `LRUPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields))

  // A hit never replaces a page.
  `LRUPR_ASSERT_NOW(a_hit_no_evict, rsp_valid && rsp_hit, !rsp_evicted_valid)

  // Without a replacement the evicted page reads as zero.
  `LRUPR_ASSERT_NOW(a_evict_page_zero, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)

  // A fault has been counted by the time it is reported.
  `LRUPR_ASSERT_NOW(a_miss_counted, rsp_valid && !rsp_hit, rsp_miss_total != '0)

  // The lookup cycle after a taken request accepts nothing.
  `LRUPR_ASSERT_NEXT(a_lookup_busy, req_valid && req_ready, !req_ready)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_hit           (rsp.hit),
  .rsp_frame_index   (rsp.frame_index),
  .rsp_evicted_valid (rsp.evicted_valid),
  .rsp_evicted_page  (rsp.evicted_page),
  .rsp_miss_total    (rsp.miss_total)
);
